// ===== hdl/linked_stack_with_free_list_macros.svh =====
// Assertion macros for the linked stack with free list.
`ifndef LINKED_STACK_WITH_FREE_LIST_MACROS_SVH
`define LINKED_STACK_WITH_FREE_LIST_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define LSFL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Condition must never be true outside reset.
`define LSFL_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define LSFL_ASSERT(label, clk, rst_n, prop)
`define LSFL_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== hdl/lsfl_pkg.sv =====
// Shared constants, types and codes for the linked stack with free list.
`default_nettype none

package lsfl_pkg;

    localparam int POOL_DEPTH    = 256;
    localparam int PAYLOAD_WIDTH = 64;

    localparam int DATA_W  = 64;
    localparam int COUNT_W = 9;
    localparam int ADDR_W  = $clog2(POOL_DEPTH);
    localparam int PTR_W   = ADDR_W + 1;
    localparam int CNT_W   = $clog2(POOL_DEPTH + 1);

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [PTR_W-1:0]         ptr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [PAYLOAD_WIDTH-1:0] pay_t;

    localparam ptr_t NULL_PTR = PTR_W'(POOL_DEPTH);

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic  rd_en;
        addr_t link_rd_addr;
        addr_t pay_rd_addr;
        logic  link_wr_en;
        logic  pay_wr_en;
        addr_t wr_addr;
        ptr_t  link_wr_data;
        pay_t  pay_wr_data;
    } mem_req_t;

    typedef struct packed {
        logic        valid;
        pay_t        data;
        status_t     status;
        cnt_t        count;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/linked_stack_with_free_list.sv =====
// Top level of the linked stack with free list: node memories, control and output register.
// Each transaction is accepted in ST_IDLE, which issues the read of the head (or free head)
// node from the node memories, whose read data is registered; ST_EXEC then updates the
// pointers, writes the node back and loads the result register. A new transaction is
// accepted while a result waits in the output register; the write-back cycle holds only if
// that register is still occupied. Pushes take recycled slots first, then never-used ones;
// a push with no slot left reports full, a pop of an empty list reports empty. No clearing
// pass runs after reset.
`default_nettype none

`include "linked_stack_with_free_list_macros.svh"

module linked_stack_with_free_list
    import lsfl_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_req_type,
    input  wire logic [DATA_W-1:0]  s_entry_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [DATA_W-1:0]  m_popped_data,
    output logic      [1:0]         m_status,
    output logic      [COUNT_W-1:0] m_entry_count
);

    mem_req_t mem_req;
    result_t  res;
    ptr_t     link_rd_data;
    pay_t     pay_rd_data;
    logic     out_busy;

    logic               m_valid_reg;
    logic [DATA_W-1:0]  m_popped_data_reg;
    logic [1:0]         m_status_reg;
    logic [COUNT_W-1:0] m_entry_count_reg;

    assign out_busy = m_valid_reg && !m_ready;

    lsfl_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_entry_data (s_entry_data),
        .out_busy     (out_busy),
        .link_rd_data (link_rd_data),
        .pay_rd_data  (pay_rd_data),
        .mem_req      (mem_req),
        .res          (res)
    );

    lsfl_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (PTR_W)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.link_wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.link_wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.link_rd_addr),
        .rd_data (link_rd_data)
    );

    lsfl_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (PAYLOAD_WIDTH)
    ) u_pay_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.pay_wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.pay_wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.pay_rd_addr),
        .rd_data (pay_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_popped_data_reg <= DATA_W'(res.data);
            m_status_reg      <= res.status;
            m_entry_count_reg <= COUNT_W'(res.count);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_popped_data = m_popped_data_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_entry_count_reg;

    `LSFL_ASSERT(a_one_in_flight, aclk, aresetn, s_valid && s_ready |=> !s_ready)
    `LSFL_ASSERT_NEVER(a_no_result_overwrite, aclk, aresetn, res.valid && out_busy)
    `LSFL_ASSERT(a_empty_pop_zero, aclk, aresetn, (m_valid && m_status == STATUS_EMPTY) |-> (m_popped_data == '0 && m_entry_count == '0))
    `LSFL_ASSERT(a_full_push_count, aclk, aresetn, (m_valid && m_status == STATUS_FULL) |-> (m_entry_count == COUNT_W'(POOL_DEPTH)))

endmodule

`default_nettype wire

// ===== hdl/lsfl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module lsfl_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lsfl_ctrl.sv =====
// List and free-list pointer control: read, modify and write back node memories.
`default_nettype none

module lsfl_ctrl
    import lsfl_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_req_type,
    input  wire logic [DATA_W-1:0] s_entry_data,
    input  wire logic              out_busy,
    input  wire ptr_t              link_rd_data,
    input  wire pay_t              pay_rd_data,
    output mem_req_t               mem_req,
    output result_t                res
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    ptr_t   list_head_reg, list_head_next;
    ptr_t   free_head_reg, free_head_next;
    cnt_t   used_reg, used_next;
    cnt_t   count_reg, count_next;
    logic   req_reg;
    pay_t   data_reg;

    logic   accept;
    logic   commit;
    logic   use_free;
    logic   can_alloc;
    logic   head_valid;
    addr_t  new_slot;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign commit  = (state_reg == ST_EXEC) && !out_busy;

    assign use_free   = (free_head_reg < NULL_PTR);
    assign can_alloc  = use_free || (used_reg < CNT_W'(POOL_DEPTH));
    assign head_valid = (list_head_reg < NULL_PTR);
    assign new_slot   = use_free ? ADDR_W'(free_head_reg) : ADDR_W'(used_reg);

    always_comb begin
        state_next     = state_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        used_next      = used_reg;
        count_next     = count_reg;

        mem_req.rd_en        = accept;
        mem_req.link_rd_addr = (s_req_type == REQ_POP) ? ADDR_W'(list_head_reg)
                                                       : ADDR_W'(free_head_reg);
        mem_req.pay_rd_addr  = ADDR_W'(list_head_reg);
        mem_req.link_wr_en   = 1'b0;
        mem_req.pay_wr_en    = 1'b0;
        mem_req.wr_addr      = new_slot;
        mem_req.link_wr_data = list_head_reg;
        mem_req.pay_wr_data  = data_reg;

        res.valid  = 1'b0;
        res.data   = '0;
        res.status = STATUS_OK;
        res.count  = count_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    state_next = ST_IDLE;
                    res.valid  = 1'b1;
                    if (req_reg == REQ_PUSH) begin
                        if (can_alloc) begin
                            mem_req.link_wr_en = 1'b1;
                            mem_req.pay_wr_en  = 1'b1;
                            list_head_next     = PTR_W'(new_slot);
                            count_next         = count_reg + 1'b1;
                            if (use_free) begin
                                free_head_next = link_rd_data;
                            end else begin
                                used_next = used_reg + 1'b1;
                            end
                        end else begin
                            res.status = STATUS_FULL;
                        end
                    end else begin
                        if (head_valid) begin
                            mem_req.link_wr_en   = 1'b1;
                            mem_req.wr_addr      = ADDR_W'(list_head_reg);
                            mem_req.link_wr_data = free_head_reg;
                            res.data             = pay_rd_data;
                            list_head_next       = link_rd_data;
                            free_head_next       = list_head_reg;
                            if (count_reg != '0) begin
                                count_next = count_reg - 1'b1;
                            end
                        end else begin
                            res.status = STATUS_EMPTY;
                        end
                    end
                    res.count = count_next;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            list_head_reg <= NULL_PTR;
            free_head_reg <= NULL_PTR;
            used_reg      <= '0;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            used_reg      <= used_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg  <= s_req_type;
            data_reg <= PAYLOAD_WIDTH'(s_entry_data);
        end
    end

endmodule

`default_nettype wire
